/* rtl/core/two_axis_clamp_release_sequencer_unit_defines.svh */
// Assertion macros shared by the sequencer RTL.
`ifndef TWO_AXIS_CLAMP_RELEASE_SEQUENCER_UNIT_DEFINES_SVH
`define TWO_AXIS_CLAMP_RELEASE_SEQUENCER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TACRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TACRS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define TACRS_ASSERT_ALWAYS(lbl, prop, msg)
`define TACRS_ASSERT_IMPLIES(lbl, ante, cons, msg)
`endif
`endif

/* rtl/core/tacrs_pkg.sv */
`default_nettype none
package tacrs_pkg;

  localparam int unsigned ModeWidth  = 3;
  localparam int unsigned StageWidth = 3;
  localparam int unsigned CodeWidth  = 3;
  localparam int unsigned InDataWidth  = 8;
  localparam int unsigned OutDataWidth = 16;

  typedef enum logic [ModeWidth-1:0] {
    MODE_TICK     = 3'd0,
    MODE_CLAMP    = 3'd1,
    MODE_RELEASE  = 3'd2,
    MODE_ESTOP    = 3'd3,
    MODE_MANUAL_X = 3'd4,
    MODE_MANUAL_Y = 3'd5
  } mode_t;

  typedef enum logic [StageWidth-1:0] {
    STAGE_IDLE    = 3'd0,
    STAGE_CLAMP_X = 3'd1,
    STAGE_CLAMP_Y = 3'd2,
    STAGE_HOLD    = 3'd3,
    STAGE_REL_X   = 3'd4,
    STAGE_REL_Y   = 3'd5
  } stage_t;

  typedef enum logic [CodeWidth-1:0] {
    CANCEL_NONE          = 3'd0,
    CANCEL_X_FAULT_CLAMP = 3'd1,
    CANCEL_Y_FAULT_CLAMP = 3'd2,
    CANCEL_NO_CLAMP      = 3'd3,
    CANCEL_X_FAULT_REL   = 3'd4,
    CANCEL_Y_FAULT_REL   = 3'd5,
    CANCEL_STOP          = 3'd6,
    CANCEL_MANUAL        = 3'd7
  } cancel_t;

  typedef struct packed {
    logic y_jogging;
    logic y_fault;
    logic y_clamped;
    logic y_running;
    logic x_jogging;
    logic x_fault;
    logic x_clamped;
    logic x_running;
  } axis_flags_t;

  typedef struct packed {
    logic                  start_x;
    logic                  start_y;
    logic                  release_x;
    logic                  release_y;
    logic                  stop_all;
    logic                  clamp_out;
    logic                  refused;
    logic [CodeWidth-1:0]  cancel_code;
    logic [StageWidth-1:0] stage_now;
  } result_t;

endpackage
`default_nettype wire

/* rtl/core/two_axis_clamp_release_sequencer_unit.sv */
`default_nettype none
// Clamp and release sequencer for two axes. Each slave transaction carries a
// mode in tuser and the status flags of both axes in tdata; each one yields
// exactly one master transaction with the strobes, the clamp level, the
// refusal flag, the cancel reason and the stage after that item. An item is
// registered on input, evaluated combinationally against the stage and clamp
// level, and written to the output register together with the new state, so
// one transaction can be accepted every cycle while the output is not stalled.
// The input side accepts while a result waits only if the input register is
// empty or the waiting result is taken in the same cycle.
`include "two_axis_clamp_release_sequencer_unit_defines.svh"
module two_axis_clamp_release_sequencer_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // Bits from 0: x_running, x_clamped, x_fault, x_jogging,
  // y_running, y_clamped, y_fault, y_jogging.
  input  wire logic [tacrs_pkg::InDataWidth-1:0]   s_tdata,
  // Bits from 0: mode.
  input  wire logic [tacrs_pkg::ModeWidth-1:0]     s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // Bits from 0: start_x, start_y, release_x, release_y, stop_all, clamp_out,
  // refused, cancel_code[2:0], stage_now[2:0], then three zero bits.
  output logic [tacrs_pkg::OutDataWidth-1:0]       m_tdata
);

  logic                                in_valid;
  logic [tacrs_pkg::ModeWidth-1:0]     in_mode;
  tacrs_pkg::axis_flags_t              in_flags;
  logic                                advance;

  tacrs_pkg::stage_t                   stage;
  tacrs_pkg::stage_t                   stage_next;
  logic                                clamp_level;
  logic                                clamp_level_next;
  tacrs_pkg::result_t                  step_result;
  tacrs_pkg::result_t                  result;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode  <= s_tuser;
      in_flags <= tacrs_pkg::axis_flags_t'(s_tdata);
    end
  end

  tacrs_step u_step (
    .mode             (in_mode),
    .flags            (in_flags),
    .stage            (stage),
    .clamp_level      (clamp_level),
    .stage_next       (stage_next),
    .clamp_level_next (clamp_level_next),
    .result           (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid    <= 1'b0;
      stage       <= tacrs_pkg::STAGE_IDLE;
      clamp_level <= 1'b0;
    end else begin
      if (advance) begin
        m_tvalid    <= 1'b1;
        stage       <= stage_next;
        clamp_level <= clamp_level_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_result;
    end
  end

  assign m_tdata = {3'b000, result.stage_now, result.cancel_code, result.refused,
                    result.clamp_out, result.stop_all, result.release_y,
                    result.release_x, result.start_y, result.start_x};

  `TACRS_ASSERT_IMPLIES(a_stage_matches, m_tvalid, result.stage_now == stage, "stage mismatch")
  `TACRS_ASSERT_IMPLIES(a_clamp_matches, m_tvalid, result.clamp_out == clamp_level, "clamp mismatch")
  `TACRS_ASSERT_IMPLIES(a_stop_drops, m_tvalid && result.stop_all, !result.clamp_out, "stop kept clamp")
  `TACRS_ASSERT_IMPLIES(a_refused_quiet, m_tvalid && result.refused, !(result.start_x || result.start_y || result.release_x || result.release_y || result.stop_all), "strobe on refusal")
  `TACRS_ASSERT_IMPLIES(a_cancel_idle, m_tvalid && (result.cancel_code != tacrs_pkg::CANCEL_NONE), (result.stage_now == tacrs_pkg::STAGE_IDLE) && !result.clamp_out, "cancel not idle")

endmodule
`default_nettype wire

/* rtl/core/tacrs_step.sv */
`default_nettype none
module tacrs_step (
  input  wire logic [tacrs_pkg::ModeWidth-1:0] mode,
  input  wire tacrs_pkg::axis_flags_t          flags,
  input  wire tacrs_pkg::stage_t               stage,
  input  wire logic                            clamp_level,
  output tacrs_pkg::stage_t                    stage_next,
  output logic                                 clamp_level_next,
  output tacrs_pkg::result_t                   result
);

  logic              sx, sy, rx, ry, stop, refused;
  tacrs_pkg::cancel_t code;
  logic              busy;

  // An abort leaves an idle sequencer untouched and reports no reason.
  assign busy = (stage != tacrs_pkg::STAGE_IDLE);

  always_comb begin
    sx = 1'b0;
    sy = 1'b0;
    rx = 1'b0;
    ry = 1'b0;
    stop = 1'b0;
    refused = 1'b0;
    code = tacrs_pkg::CANCEL_NONE;
    stage_next = stage;
    clamp_level_next = clamp_level;
    unique case (tacrs_pkg::mode_t'(mode))
      tacrs_pkg::MODE_TICK: begin
        unique case (stage)
          tacrs_pkg::STAGE_CLAMP_X: begin
            if (!flags.x_running) begin
              if (flags.x_fault) begin
                code = tacrs_pkg::CANCEL_X_FAULT_CLAMP;
                stage_next = tacrs_pkg::STAGE_IDLE;
                clamp_level_next = 1'b0;
              end else begin
                sy = 1'b1;
                stage_next = tacrs_pkg::STAGE_CLAMP_Y;
              end
            end
          end
          tacrs_pkg::STAGE_CLAMP_Y: begin
            if (!flags.y_running) begin
              if (flags.y_fault) begin
                code = tacrs_pkg::CANCEL_Y_FAULT_CLAMP;
                stage_next = tacrs_pkg::STAGE_IDLE;
                clamp_level_next = 1'b0;
              end else if (flags.x_clamped && flags.y_clamped) begin
                stage_next = tacrs_pkg::STAGE_HOLD;
                clamp_level_next = 1'b1;
              end else begin
                code = tacrs_pkg::CANCEL_NO_CLAMP;
                stage_next = tacrs_pkg::STAGE_IDLE;
                clamp_level_next = 1'b0;
              end
            end
          end
          tacrs_pkg::STAGE_REL_X: begin
            if (!flags.x_running) begin
              if (flags.x_fault) begin
                code = tacrs_pkg::CANCEL_X_FAULT_REL;
                stage_next = tacrs_pkg::STAGE_IDLE;
                clamp_level_next = 1'b0;
              end else if (flags.y_clamped) begin
                ry = 1'b1;
                stage_next = tacrs_pkg::STAGE_REL_Y;
              end else begin
                stage_next = tacrs_pkg::STAGE_IDLE;
              end
            end
          end
          tacrs_pkg::STAGE_REL_Y: begin
            if (!flags.y_running) begin
              if (flags.y_fault) begin
                code = tacrs_pkg::CANCEL_Y_FAULT_REL;
                clamp_level_next = 1'b0;
              end
              stage_next = tacrs_pkg::STAGE_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
      tacrs_pkg::MODE_CLAMP: begin
        if (flags.x_running || flags.y_running) begin
          refused = 1'b1;
        end else begin
          sx = 1'b1;
          stage_next = tacrs_pkg::STAGE_CLAMP_X;
        end
      end
      tacrs_pkg::MODE_RELEASE: begin
        if (!flags.x_clamped && !flags.y_clamped) begin
          refused = 1'b1;
        end else begin
          clamp_level_next = 1'b0;
          if (flags.x_clamped) begin
            rx = 1'b1;
            stage_next = tacrs_pkg::STAGE_REL_X;
          end else begin
            ry = 1'b1;
            stage_next = tacrs_pkg::STAGE_REL_Y;
          end
        end
      end
      tacrs_pkg::MODE_ESTOP: begin
        stop = 1'b1;
        clamp_level_next = 1'b0;
        if (busy) begin
          code = tacrs_pkg::CANCEL_STOP;
          stage_next = tacrs_pkg::STAGE_IDLE;
        end
      end
      tacrs_pkg::MODE_MANUAL_X: begin
        if (flags.y_running || flags.y_jogging) begin
          refused = 1'b1;
        end else begin
          sx = 1'b1;
          if (busy) begin
            code = tacrs_pkg::CANCEL_MANUAL;
            stage_next = tacrs_pkg::STAGE_IDLE;
            clamp_level_next = 1'b0;
          end
        end
      end
      tacrs_pkg::MODE_MANUAL_Y: begin
        if (flags.x_running || flags.x_jogging) begin
          refused = 1'b1;
        end else begin
          sy = 1'b1;
          if (busy) begin
            code = tacrs_pkg::CANCEL_MANUAL;
            stage_next = tacrs_pkg::STAGE_IDLE;
            clamp_level_next = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.start_x     = sx;
    result.start_y     = sy;
    result.release_x   = rx;
    result.release_y   = ry;
    result.stop_all    = stop;
    result.clamp_out   = clamp_level_next;
    result.refused     = refused;
    result.cancel_code = code;
    result.stage_now   = stage_next;
  end

endmodule
`default_nettype wire

/* tb/sv/clamp_seq_checker.sv */
`timescale 1ns / 1ps
module clamp_seq_checker
  import tacrs_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  input  wire logic                    s_tready,
  input  wire logic [InDataWidth-1:0]  s_tdata,
  input  wire logic [ModeWidth-1:0]    s_tuser,
  input  wire logic                    m_tvalid,
  input  wire logic                    m_tready,
  input  wire logic [OutDataWidth-1:0] m_tdata,
  output int                           fail_count,
  output int                           pending_count,
  output int                           checked_count,
  output int                           hold_count,
  output int                           cancel_count,
  output int                           refusal_count
);

  stage_t      stage_q;
  logic        clamp_q;
  result_t     expected_results[$];
  int          errors;
  int          checked;
  int          holds;
  int          cancels;
  int          refusals;

  initial begin
    stage_q       = STAGE_IDLE;
    clamp_q       = 1'b0;
    errors        = 0;
    checked       = 0;
    holds         = 0;
    cancels       = 0;
    refusals      = 0;
    fail_count    = 0;
    pending_count = 0;
    checked_count = 0;
    hold_count    = 0;
    cancel_count  = 0;
    refusal_count = 0;
  end

  function automatic logic [CodeWidth-1:0] cancel_sequence(cancel_t reason);
    if (stage_q == STAGE_IDLE) begin
      return CANCEL_NONE;
    end
    stage_q = STAGE_IDLE;
    clamp_q = 1'b0;
    return reason;
  endfunction

  function automatic result_t next_result(logic [ModeWidth-1:0] mode, axis_flags_t f);
    result_t r;
    r = '0;
    case (mode)
      MODE_TICK: begin
        case (stage_q)
          STAGE_CLAMP_X: if (!f.x_running) begin
            if (f.x_fault) begin
              r.cancel_code = cancel_sequence(CANCEL_X_FAULT_CLAMP);
            end else begin
              r.start_y = 1'b1;
              stage_q   = STAGE_CLAMP_Y;
            end
          end
          STAGE_CLAMP_Y: if (!f.y_running) begin
            if (f.y_fault) begin
              r.cancel_code = cancel_sequence(CANCEL_Y_FAULT_CLAMP);
            end else if (f.x_clamped && f.y_clamped) begin
              stage_q = STAGE_HOLD;
              clamp_q = 1'b1;
            end else begin
              r.cancel_code = cancel_sequence(CANCEL_NO_CLAMP);
            end
          end
          STAGE_REL_X: if (!f.x_running) begin
            if (f.x_fault) begin
              r.cancel_code = cancel_sequence(CANCEL_X_FAULT_REL);
            end else if (f.y_clamped) begin
              r.release_y = 1'b1;
              stage_q     = STAGE_REL_Y;
            end else begin
              stage_q = STAGE_IDLE;
            end
          end
          STAGE_REL_Y: if (!f.y_running) begin
            if (f.y_fault) begin
              r.cancel_code = cancel_sequence(CANCEL_Y_FAULT_REL);
            end else begin
              stage_q = STAGE_IDLE;
            end
          end
          default: ;
        endcase
      end
      MODE_CLAMP: begin
        if (f.x_running || f.y_running) begin
          r.refused = 1'b1;
        end else begin
          r.start_x = 1'b1;
          stage_q   = STAGE_CLAMP_X;
        end
      end
      MODE_RELEASE: begin
        if (!f.x_clamped && !f.y_clamped) begin
          r.refused = 1'b1;
        end else begin
          clamp_q = 1'b0;
          if (f.x_clamped) begin
            r.release_x = 1'b1;
            stage_q     = STAGE_REL_X;
          end else begin
            r.release_y = 1'b1;
            stage_q     = STAGE_REL_Y;
          end
        end
      end
      MODE_ESTOP: begin
        r.cancel_code = cancel_sequence(CANCEL_STOP);
        clamp_q       = 1'b0;
        r.stop_all    = 1'b1;
      end
      MODE_MANUAL_X: begin
        if (f.y_running || f.y_jogging) begin
          r.refused = 1'b1;
        end else begin
          r.cancel_code = cancel_sequence(CANCEL_MANUAL);
          r.start_x     = 1'b1;
        end
      end
      MODE_MANUAL_Y: begin
        if (f.x_running || f.x_jogging) begin
          r.refused = 1'b1;
        end else begin
          r.cancel_code = cancel_sequence(CANCEL_MANUAL);
          r.start_y     = 1'b1;
        end
      end
      default: ;
    endcase
    r.clamp_out = clamp_q;
    r.stage_now = stage_q;
    return r;
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    stage_t  prior_stage;
    if (rst) begin
      stage_q = STAGE_IDLE;
      clamp_q = 1'b0;
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.start_x     = m_tdata[0];
        got.start_y     = m_tdata[1];
        got.release_x   = m_tdata[2];
        got.release_y   = m_tdata[3];
        got.stop_all    = m_tdata[4];
        got.clamp_out   = m_tdata[5];
        got.refused     = m_tdata[6];
        got.cancel_code = m_tdata[9:7];
        got.stage_now   = m_tdata[12:10];
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t ns: result with no expectation waiting, expected none, actual 0x%04h",
                   $time, m_tdata);
        end else begin
          want = expected_results.pop_front();
          checked++;
          compare_field("start_x", want.start_x, got.start_x);
          compare_field("start_y", want.start_y, got.start_y);
          compare_field("release_x", want.release_x, got.release_x);
          compare_field("release_y", want.release_y, got.release_y);
          compare_field("stop_all", want.stop_all, got.stop_all);
          compare_field("clamp_out", want.clamp_out, got.clamp_out);
          compare_field("refused", want.refused, got.refused);
          compare_field("cancel_code", want.cancel_code, got.cancel_code);
          compare_field("stage_now", want.stage_now, got.stage_now);
          compare_field("padding", 0, m_tdata[15:13]);
        end
      end
      if (s_tvalid && s_tready) begin
        prior_stage = stage_q;
        want = next_result(s_tuser, axis_flags_t'(s_tdata));
        if (want.cancel_code != CANCEL_NONE) begin
          cancels++;
        end
        if (want.refused) begin
          refusals++;
        end
        if (prior_stage != STAGE_HOLD && stage_q == STAGE_HOLD) begin
          holds++;
        end
        expected_results.push_back(want);
      end
    end
    fail_count    <= errors;
    pending_count <= expected_results.size();
    checked_count <= checked;
    hold_count    <= holds;
    cancel_count  <= cancels;
    refusal_count <= refusals;
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import tacrs_pkg::*;

  localparam int RANDOM_ITEMS = 1550;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_OFF     = 300;
  localparam logic [ModeWidth-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [ModeWidth-1:0] MODE_SPARE_7 = 3'd7;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [InDataWidth-1:0]  s_tdata = '0;
  logic [ModeWidth-1:0]    s_tuser = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OutDataWidth-1:0] m_tdata;

  int fail_count;
  int pending_count;
  int checked_count;
  int hold_count;
  int cancel_count;
  int refusal_count;
  int items_sent = 0;
  int cycles = 0;
  bit no_gaps = 1'b0;
  bit hold_off_req = 1'b0;
  bit hold_off_done = 1'b0;

  always #4 clk = ~clk;

  two_axis_clamp_release_sequencer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  clamp_seq_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count),
    .hold_count    (hold_count),
    .cancel_count  (cancel_count),
    .refusal_count (refusal_count)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles, pending_count);
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic axis_flags_t flags_of(bit xr, bit xc, bit xf, bit xj,
                                           bit yr, bit yc, bit yf, bit yj);
    axis_flags_t f;
    f.x_running = xr;
    f.x_clamped = xc;
    f.x_fault   = xf;
    f.x_jogging = xj;
    f.y_running = yr;
    f.y_clamped = yc;
    f.y_fault   = yf;
    f.y_jogging = yj;
    return f;
  endfunction

  function automatic axis_flags_t random_flags();
    axis_flags_t f;
    f.x_running = ($urandom_range(0, 3) == 0);
    f.x_clamped = ($urandom_range(0, 7) != 0);
    f.x_fault   = ($urandom_range(0, 15) == 0);
    f.x_jogging = ($urandom_range(0, 7) == 0);
    f.y_running = ($urandom_range(0, 3) == 0);
    f.y_clamped = ($urandom_range(0, 7) != 0);
    f.y_fault   = ($urandom_range(0, 15) == 0);
    f.y_jogging = ($urandom_range(0, 7) == 0);
    return f;
  endfunction

  task automatic send_item(logic [ModeWidth-1:0] mode, axis_flags_t f);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= f;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_noise();
    send_item(ModeWidth'($urandom_range(MODE_TICK, MODE_MANUAL_Y)),
              axis_flags_t'($urandom_range(0, 255)));
  endtask

  // Occasionally breaks into a well-formed sequence with an arbitrary command.
  task automatic sequence_item(logic [ModeWidth-1:0] mode, axis_flags_t f);
    if ($urandom_range(0, 24) == 0) begin
      send_noise();
    end
    send_item(mode, f);
  endtask

  task automatic wait_on_axis(bit on_x);
    axis_flags_t f;
    int          n;
    n = $urandom_range(0, 3);
    repeat (n) begin
      f = random_flags();
      if (on_x) begin
        f.x_running = 1'b1;
      end else begin
        f.y_running = 1'b1;
      end
      sequence_item(MODE_TICK, f);
    end
    f = random_flags();
    if (on_x) begin
      f.x_running = 1'b0;
    end else begin
      f.y_running = 1'b0;
    end
    sequence_item(MODE_TICK, f);
  endtask

  task automatic clamp_release_cycle();
    axis_flags_t f;
    int          n;
    f = random_flags();
    if ($urandom_range(0, 9) != 0) begin
      f.x_running = 1'b0;
      f.y_running = 1'b0;
    end
    sequence_item(MODE_CLAMP, f);
    wait_on_axis(1'b1);
    wait_on_axis(1'b0);
    n = $urandom_range(0, 3);
    repeat (n) sequence_item(MODE_TICK, random_flags());
    sequence_item(MODE_RELEASE, random_flags());
    wait_on_axis(1'b1);
    wait_on_axis(1'b0);
  endtask

  initial begin
    int n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(MODE_TICK,    flags_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_item(MODE_CLAMP,   flags_of(1, 0, 0, 0, 0, 0, 0, 0));
    send_item(MODE_CLAMP,   flags_of(0, 0, 0, 0, 1, 0, 0, 0));
    send_item(MODE_CLAMP,   flags_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_item(MODE_TICK,    flags_of(1, 0, 1, 0, 0, 0, 0, 0));
    send_item(MODE_TICK,    flags_of(0, 0, 1, 0, 0, 0, 0, 0));
    send_item(MODE_CLAMP,   flags_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_item(MODE_TICK,    flags_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_item(MODE_TICK,    flags_of(0, 0, 0, 0, 0, 0, 1, 0));
    send_item(MODE_CLAMP,   flags_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_item(MODE_TICK,    flags_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_item(MODE_TICK,    flags_of(0, 1, 0, 0, 1, 1, 1, 0));
    send_item(MODE_TICK,    flags_of(0, 1, 0, 0, 0, 1, 0, 0));
    send_item(MODE_RELEASE, flags_of(0, 1, 0, 0, 0, 1, 0, 0));
    send_item(MODE_TICK,    flags_of(0, 0, 0, 0, 0, 1, 0, 0));
    send_item(MODE_TICK,    flags_of(0, 0, 0, 0, 0, 0, 1, 0));
    send_item(MODE_RELEASE, flags_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_item(MODE_RELEASE, flags_of(0, 0, 0, 0, 0, 1, 0, 0));
    send_item(MODE_TICK,    flags_of(0, 0, 0, 0, 0, 1, 0, 0));
    send_item(MODE_RELEASE, flags_of(0, 1, 0, 0, 0, 0, 0, 0));
    send_item(MODE_TICK,    flags_of(0, 0, 1, 0, 0, 0, 0, 0));
    send_item(MODE_RELEASE, flags_of(0, 1, 0, 0, 0, 0, 0, 0));
    send_item(MODE_TICK,    flags_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_item(MODE_CLAMP,   flags_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_item(MODE_TICK,    flags_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_item(MODE_TICK,    flags_of(0, 1, 0, 0, 0, 0, 0, 0));
    send_item(MODE_ESTOP,   flags_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_item(MODE_CLAMP,   flags_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_item(MODE_ESTOP,   flags_of(1, 1, 1, 1, 1, 1, 1, 1));
    send_item(MODE_MANUAL_X, flags_of(0, 0, 0, 0, 1, 0, 0, 0));
    send_item(MODE_MANUAL_X, flags_of(0, 0, 0, 0, 0, 0, 0, 1));
    send_item(MODE_MANUAL_Y, flags_of(1, 0, 0, 0, 0, 0, 0, 0));
    send_item(MODE_MANUAL_Y, flags_of(0, 0, 0, 1, 0, 0, 0, 0));
    send_item(MODE_CLAMP,   flags_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_item(MODE_MANUAL_X, flags_of(1, 1, 1, 1, 0, 1, 1, 0));
    send_item(MODE_MANUAL_Y, flags_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_item(MODE_SPARE_6, flags_of(1, 1, 1, 1, 1, 1, 1, 1));
    send_item(MODE_SPARE_7, flags_of(0, 1, 0, 1, 0, 1, 0, 1));

    n = items_sent + RANDOM_ITEMS;
    while (items_sent < n) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if (!hold_off_done && items_sent > n - RANDOM_ITEMS / 2 && hold_count > 0 &&
          $urandom_range(0, 20) == 0) begin
        hold_off_done = 1'b1;
        hold_off_req  = 1'b1;
        no_gaps       = 1'b1;
        repeat (40) send_noise();
      end else if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 5)) send_noise();
      end else begin
        clamp_release_cycle();
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d transactions and checked %0d results.", items_sent, checked_count);
    $display("Clamp holds reached: %0d, sequences cancelled: %0d, commands refused: %0d.",
             hold_count, cancel_count, refusal_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

endmodule
